[rtl/core/alfl_pkg.sv]
// Shared types, constants and helpers for the array linked list with free list.
`default_nettype none

package alfl_pkg;

    localparam int NODE_COUNT = 64;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int PTR_W      = IDX_W + 1;
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;

    // Any pointer at or beyond NODE_COUNT means "no node"; this is the one we write.
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_FRONT = 3'd0,
        KIND_ADD_BACK  = 3'd1,
        KIND_INSERT    = 3'd2,
        KIND_REM_FRONT = 3'd3,
        KIND_REM_BACK  = 3'd4,
        KIND_REM_AFTER = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_TAKE,
        S_TAKE_WR,
        S_LINK_WR,
        S_REM_CHK,
        S_WALK,
        S_FREE_WR,
        S_DONE
    } state_t;

    // Access request from the sequencer to the node store.
    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              data_we;
        logic [IDX_W-1:0]  data_addr;
        logic [DATA_W-1:0] data_wdata;
        logic              link_we;
        logic [IDX_W-1:0]  link_addr;
        logic [PTR_W-1:0]  link_wdata;
    } store_req_t;

    function automatic logic is_null(input logic [PTR_W-1:0] p);
        return p >= PTR_W'(NODE_COUNT);
    endfunction

endpackage

`default_nettype wire

[rtl/core/alfl_ram.sv]
// Generic single write port RAM with a registered read port.
`default_nettype none

module alfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/alfl_store.sv]
// Node store: data and link memories, with per-entry valid bits for the link reset values.
`default_nettype none

module alfl_store (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire alfl_pkg::store_req_t          req,
    output logic      [alfl_pkg::DATA_W-1:0]   data_rdata,
    output logic      [alfl_pkg::PTR_W-1:0]    link_rdata
);

    logic [alfl_pkg::NODE_COUNT-1:0] link_vld_reg;
    logic [alfl_pkg::NODE_COUNT-1:0] link_vld_next;
    logic                            rd_vld_reg;
    logic [alfl_pkg::IDX_W-1:0]      rd_addr_reg;
    logic [alfl_pkg::PTR_W-1:0]      link_ram_rdata;

    alfl_ram #(
        .WIDTH (alfl_pkg::DATA_W),
        .DEPTH (alfl_pkg::NODE_COUNT)
    ) u_data_ram (
        .clk   (clk),
        .we    (req.data_we),
        .waddr (req.data_addr),
        .wdata (req.data_wdata),
        .raddr (req.rd_addr),
        .rdata (data_rdata)
    );

    alfl_ram #(
        .WIDTH (alfl_pkg::PTR_W),
        .DEPTH (alfl_pkg::NODE_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (req.link_we),
        .waddr (req.link_addr),
        .wdata (req.link_wdata),
        .raddr (req.rd_addr),
        .rdata (link_ram_rdata)
    );

    always_comb
    begin
        link_vld_next = link_vld_reg;
        if (req.link_we)
        begin
            link_vld_next[req.link_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
        end
        else
        begin
            link_vld_reg <= link_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_vld_reg  <= link_vld_reg[req.rd_addr];
        rd_addr_reg <= req.rd_addr;
    end

    // An entry never written still holds the free chain of reset: the next index,
    // which for the last entry is the null mark.
    assign link_rdata = rd_vld_reg ? link_ram_rdata
                                   : alfl_pkg::PTR_W'({1'b0, rd_addr_reg})
                                     + alfl_pkg::PTR_W'(1);

endmodule

`default_nettype wire

[rtl/core/alfl_ctrl.sv]
// Sequencer that walks and rewrites the node store, one access per cycle.
`default_nettype none

module alfl_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic [alfl_pkg::KIND_W-1:0]     kind,
    input  wire logic signed [alfl_pkg::DATA_W-1:0] value,
    input  wire logic signed [alfl_pkg::DATA_W-1:0] key,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic      [alfl_pkg::STATUS_W-1:0]   status,
    output logic signed [alfl_pkg::DATA_W-1:0]   removed_value,
    output alfl_pkg::store_req_t                 store_req,
    input  wire logic [alfl_pkg::DATA_W-1:0]     data_rdata,
    input  wire logic [alfl_pkg::PTR_W-1:0]      link_rdata
);

    alfl_pkg::state_t                state_reg, state_next;
    alfl_pkg::kind_t                 kind_reg, kind_next;
    logic [alfl_pkg::DATA_W-1:0]     value_reg, value_next;
    logic [alfl_pkg::DATA_W-1:0]     key_reg, key_next;
    logic [alfl_pkg::PTR_W-1:0]      free_head_reg, free_head_next;
    logic [alfl_pkg::PTR_W-1:0]      head_reg, head_next;
    logic [alfl_pkg::PTR_W-1:0]      tail_reg, tail_next;
    logic [alfl_pkg::PTR_W-1:0]      cur_reg, cur_next;
    logic [alfl_pkg::PTR_W-1:0]      n_reg, n_next;
    logic [alfl_pkg::PTR_W-1:0]      k_reg, k_next;
    logic [alfl_pkg::PTR_W-1:0]      klink_reg, klink_next;
    alfl_pkg::status_t               status_reg, status_next;
    logic [alfl_pkg::DATA_W-1:0]     removed_reg, removed_next;
    logic                            out_valid_reg, out_valid_next;
    alfl_pkg::status_t               out_status_reg, out_status_next;
    logic [alfl_pkg::DATA_W-1:0]     out_removed_reg, out_removed_next;

    logic accept;
    logic out_free;
    logic free_null;
    logic head_null;
    logic link_null;
    logic hit;

    assign req_stall     = (state_reg != alfl_pkg::S_IDLE);
    assign accept        = req_valid && !req_stall;
    assign out_free      = !out_valid_reg || !rsp_stall;
    assign free_null     = alfl_pkg::is_null(free_head_reg);
    assign head_null     = alfl_pkg::is_null(head_reg);
    assign link_null     = alfl_pkg::is_null(link_rdata);
    assign hit           = (data_rdata == key_reg);

    assign rsp_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign removed_value = out_removed_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alfl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = alfl_pkg::S_DECIDE;
                end
            end
            alfl_pkg::S_DECIDE:
            begin
                case (kind_reg)
                    alfl_pkg::KIND_ADD_FRONT,
                    alfl_pkg::KIND_ADD_BACK:
                    begin
                        state_next = free_null ? alfl_pkg::S_DONE : alfl_pkg::S_TAKE;
                    end
                    alfl_pkg::KIND_INSERT:
                    begin
                        if (free_null)
                        begin
                            state_next = alfl_pkg::S_DONE;
                        end
                        else if (head_null)
                        begin
                            state_next = alfl_pkg::S_TAKE;
                        end
                        else
                        begin
                            state_next = alfl_pkg::S_SEARCH;
                        end
                    end
                    alfl_pkg::KIND_REM_FRONT,
                    alfl_pkg::KIND_REM_BACK:
                    begin
                        state_next = head_null ? alfl_pkg::S_DONE : alfl_pkg::S_REM_CHK;
                    end
                    alfl_pkg::KIND_REM_AFTER:
                    begin
                        state_next = head_null ? alfl_pkg::S_DONE : alfl_pkg::S_SEARCH;
                    end
                    default:
                    begin
                        state_next = alfl_pkg::S_DONE;
                    end
                endcase
            end
            alfl_pkg::S_SEARCH:
            begin
                if (hit && kind_reg == alfl_pkg::KIND_INSERT)
                begin
                    state_next = alfl_pkg::S_TAKE;
                end
                else if (link_null)
                begin
                    state_next = alfl_pkg::S_DONE;
                end
                else if (hit)
                begin
                    state_next = alfl_pkg::S_REM_CHK;
                end
            end
            alfl_pkg::S_TAKE:
            begin
                state_next = alfl_pkg::S_TAKE_WR;
            end
            alfl_pkg::S_TAKE_WR:
            begin
                if (head_null || kind_reg == alfl_pkg::KIND_ADD_FRONT)
                begin
                    state_next = alfl_pkg::S_DONE;
                end
                else
                begin
                    state_next = alfl_pkg::S_LINK_WR;
                end
            end
            alfl_pkg::S_LINK_WR:
            begin
                state_next = alfl_pkg::S_DONE;
            end
            alfl_pkg::S_REM_CHK:
            begin
                if (kind_reg == alfl_pkg::KIND_REM_BACK && n_reg != head_reg)
                begin
                    state_next = alfl_pkg::S_WALK;
                end
                else
                begin
                    state_next = alfl_pkg::S_FREE_WR;
                end
            end
            alfl_pkg::S_WALK:
            begin
                if (link_rdata == n_reg || link_null)
                begin
                    state_next = alfl_pkg::S_FREE_WR;
                end
            end
            alfl_pkg::S_FREE_WR:
            begin
                state_next = alfl_pkg::S_DONE;
            end
            alfl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = alfl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = alfl_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath updates and store accesses.
    always_comb
    begin
        kind_next        = kind_reg;
        value_next       = value_reg;
        key_next         = key_reg;
        free_head_next   = free_head_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        cur_next         = cur_reg;
        n_next           = n_reg;
        k_next           = k_reg;
        klink_next       = klink_reg;
        status_next      = status_reg;
        removed_next     = removed_reg;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_valid_next   = out_valid_reg && rsp_stall;
        store_req        = '0;

        case (state_reg)
            alfl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = alfl_pkg::kind_t'(kind);
                    value_next   = value;
                    key_next     = key;
                    status_next  = alfl_pkg::ST_OK;
                    removed_next = '0;
                end
            end
            alfl_pkg::S_DECIDE:
            begin
                case (kind_reg)
                    alfl_pkg::KIND_ADD_FRONT,
                    alfl_pkg::KIND_ADD_BACK,
                    alfl_pkg::KIND_INSERT:
                    begin
                        k_next = tail_reg;
                        if (free_null)
                        begin
                            status_next = alfl_pkg::ST_FULL;
                        end
                        else if (kind_reg == alfl_pkg::KIND_INSERT && !head_null)
                        begin
                            cur_next          = head_reg;
                            store_req.rd_addr = head_reg[alfl_pkg::IDX_W-1:0];
                        end
                    end
                    alfl_pkg::KIND_REM_FRONT:
                    begin
                        if (head_null)
                        begin
                            status_next = alfl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            n_next            = head_reg;
                            store_req.rd_addr = head_reg[alfl_pkg::IDX_W-1:0];
                        end
                    end
                    alfl_pkg::KIND_REM_BACK:
                    begin
                        if (head_null)
                        begin
                            status_next = alfl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            n_next            = tail_reg;
                            store_req.rd_addr = tail_reg[alfl_pkg::IDX_W-1:0];
                        end
                    end
                    alfl_pkg::KIND_REM_AFTER:
                    begin
                        if (head_null)
                        begin
                            status_next = alfl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cur_next          = head_reg;
                            store_req.rd_addr = head_reg[alfl_pkg::IDX_W-1:0];
                        end
                    end
                    default:
                    begin
                        status_next = alfl_pkg::ST_OK;
                    end
                endcase
            end
            alfl_pkg::S_SEARCH:
            begin
                // The node read last cycle is checked while its successor is fetched.
                if (hit)
                begin
                    k_next     = cur_reg;
                    klink_next = link_rdata;
                    if (kind_reg == alfl_pkg::KIND_REM_AFTER)
                    begin
                        if (link_null)
                        begin
                            status_next = alfl_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            n_next            = link_rdata;
                            store_req.rd_addr = link_rdata[alfl_pkg::IDX_W-1:0];
                        end
                    end
                end
                else if (link_null)
                begin
                    status_next = alfl_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    cur_next          = link_rdata;
                    store_req.rd_addr = link_rdata[alfl_pkg::IDX_W-1:0];
                end
            end
            alfl_pkg::S_TAKE:
            begin
                n_next               = free_head_reg;
                store_req.rd_addr    = free_head_reg[alfl_pkg::IDX_W-1:0];
                store_req.data_we    = 1'b1;
                store_req.data_addr  = free_head_reg[alfl_pkg::IDX_W-1:0];
                store_req.data_wdata = value_reg;
            end
            alfl_pkg::S_TAKE_WR:
            begin
                free_head_next      = link_rdata;
                store_req.link_we   = 1'b1;
                store_req.link_addr = n_reg[alfl_pkg::IDX_W-1:0];
                if (head_null)
                begin
                    store_req.link_wdata = alfl_pkg::NIL;
                    head_next            = n_reg;
                    tail_next            = n_reg;
                end
                else
                begin
                    case (kind_reg)
                        alfl_pkg::KIND_ADD_FRONT:
                        begin
                            store_req.link_wdata = head_reg;
                            head_next            = n_reg;
                        end
                        alfl_pkg::KIND_INSERT:
                        begin
                            store_req.link_wdata = klink_reg;
                        end
                        default:
                        begin
                            store_req.link_wdata = alfl_pkg::NIL;
                        end
                    endcase
                end
            end
            alfl_pkg::S_LINK_WR:
            begin
                // For an add at the back the anchor node is the old tail.
                store_req.link_we    = 1'b1;
                store_req.link_addr  = k_reg[alfl_pkg::IDX_W-1:0];
                store_req.link_wdata = n_reg;
                if (k_reg == tail_reg)
                begin
                    tail_next = n_reg;
                end
            end
            alfl_pkg::S_REM_CHK:
            begin
                removed_next = data_rdata;
                case (kind_reg)
                    alfl_pkg::KIND_REM_FRONT:
                    begin
                        head_next = link_rdata;
                        if (link_null)
                        begin
                            tail_next = alfl_pkg::NIL;
                        end
                    end
                    alfl_pkg::KIND_REM_BACK:
                    begin
                        if (n_reg == head_reg)
                        begin
                            head_next = alfl_pkg::NIL;
                            tail_next = alfl_pkg::NIL;
                        end
                        else
                        begin
                            cur_next          = head_reg;
                            store_req.rd_addr = head_reg[alfl_pkg::IDX_W-1:0];
                        end
                    end
                    default:
                    begin
                        store_req.link_we    = 1'b1;
                        store_req.link_addr  = k_reg[alfl_pkg::IDX_W-1:0];
                        store_req.link_wdata = link_rdata;
                        if (n_reg == tail_reg)
                        begin
                            tail_next = k_reg;
                        end
                    end
                endcase
            end
            alfl_pkg::S_WALK:
            begin
                if (link_rdata == n_reg)
                begin
                    store_req.link_we    = 1'b1;
                    store_req.link_addr  = cur_reg[alfl_pkg::IDX_W-1:0];
                    store_req.link_wdata = alfl_pkg::NIL;
                    tail_next            = cur_reg;
                end
                else if (!link_null)
                begin
                    cur_next          = link_rdata;
                    store_req.rd_addr = link_rdata[alfl_pkg::IDX_W-1:0];
                end
            end
            alfl_pkg::S_FREE_WR:
            begin
                store_req.link_we    = 1'b1;
                store_req.link_addr  = n_reg[alfl_pkg::IDX_W-1:0];
                store_req.link_wdata = free_head_reg;
                free_head_next       = n_reg;
            end
            alfl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status_reg;
                    out_removed_next = removed_reg;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alfl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            free_head_reg <= '0;
            head_reg      <= alfl_pkg::NIL;
            tail_reg      <= alfl_pkg::NIL;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            free_head_reg <= free_head_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        value_reg       <= value_next;
        key_reg         <= key_next;
        cur_reg         <= cur_next;
        n_reg           <= n_next;
        k_reg           <= k_next;
        klink_reg       <= klink_next;
        status_reg      <= status_next;
        removed_reg     <= removed_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
    end

endmodule

`default_nettype wire

[rtl/core/array_linked_list_free_list_core.sv]
// A full store, an empty list or an unused kind goes from decode straight to the result.
// An add or a front removal first writes the links of the node taken or freed; key searches
// and back removal first walk the list node by node, one node store read for each.
// One transaction is in work at a time, taken at the edge after the previous result is
// registered, even while that result still waits.
// Reset empties the list and frees every node at once; no clearing pass is needed.
`default_nettype none

module array_linked_list_free_list_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire logic        [alfl_pkg::KIND_W-1:0]   kind,
    input  wire logic signed [alfl_pkg::DATA_W-1:0]   value,
    input  wire logic signed [alfl_pkg::DATA_W-1:0]   key,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output logic             [alfl_pkg::STATUS_W-1:0] status,
    output logic signed      [alfl_pkg::DATA_W-1:0]   removed_value
);

    alfl_pkg::store_req_t         store_req;
    logic [alfl_pkg::DATA_W-1:0]  data_rdata;
    logic [alfl_pkg::PTR_W-1:0]   link_rdata;

    alfl_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (store_req),
        .data_rdata (data_rdata),
        .link_rdata (link_rdata)
    );

    alfl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .kind          (kind),
        .value         (value),
        .key           (key),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .removed_value (removed_value),
        .store_req     (store_req),
        .data_rdata    (data_rdata),
        .link_rdata    (link_rdata)
    );

endmodule

`default_nettype wire

[tb/sv/tb_array_linked_list_free_list_core.sv]
// Self-checking testbench for the array linked list core with its free chain of slots.
`timescale 1ns / 1ps

module tb_array_linked_list_free_list_core;

    localparam int NODES = alfl_pkg::NODE_COUNT;

    // Kind codes that the block treats as a no-op.
    localparam logic [alfl_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [alfl_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam logic [alfl_pkg::DATA_W-1:0] DATA_MIN = 32'h8000_0000;
    localparam logic [alfl_pkg::DATA_W-1:0] DATA_MAX = 32'h7fff_ffff;
    localparam logic [alfl_pkg::DATA_W-1:0] DATA_NEG1 = 32'hffff_ffff;

    typedef logic [alfl_pkg::PTR_W-1:0] ptr_t;

    typedef struct packed {
        logic [alfl_pkg::KIND_W-1:0] kind;
        logic [alfl_pkg::DATA_W-1:0] value;
        logic [alfl_pkg::DATA_W-1:0] key;
    } list_req_t;

    typedef struct packed {
        alfl_pkg::status_t           status;
        logic [alfl_pkg::DATA_W-1:0] removed;
    } list_reply_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 req_valid = 1'b0;
    logic                                 req_stall;
    logic        [alfl_pkg::KIND_W-1:0]   req_kind = '0;
    logic signed [alfl_pkg::DATA_W-1:0]   req_value = '0;
    logic signed [alfl_pkg::DATA_W-1:0]   req_key = '0;
    logic                                 rsp_valid;
    logic                                 rsp_stall = 1'b0;
    logic        [alfl_pkg::STATUS_W-1:0] status;
    logic signed [alfl_pkg::DATA_W-1:0]   removed_value;

    // Shadow copy of the node store and the list pointers.
    logic [alfl_pkg::DATA_W-1:0] shadow_data [NODES];
    ptr_t                        shadow_link [NODES];
    ptr_t                        shadow_free;
    ptr_t                        shadow_head;
    ptr_t                        shadow_tail;

    list_req_t   req_backlog [$];
    list_reply_t awaited_replies [$];
    list_req_t   next_req;

    bit req_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int requests_queued = 0;
    int requests_accepted = 0;
    int replies_checked = 0;
    int failures = 0;
    int status_seen [4] = '{default: 0};

    array_linked_list_free_list_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .kind          (req_kind),
        .value         (req_value),
        .key           (req_key),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .removed_value (removed_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_node(ptr_t p);
        return int'(p) < NODES;
    endfunction

    function automatic logic [alfl_pkg::IDX_W-1:0] slot(ptr_t p);
        return p[alfl_pkg::IDX_W-1:0];
    endfunction

    function automatic ptr_t find_first(logic [alfl_pkg::DATA_W-1:0] k);
        ptr_t cur;
        int   n;
        cur = shadow_head;
        for (n = 0; n < NODES && is_node(cur); n++)
        begin
            if (shadow_data[slot(cur)] == k)
                return cur;
            cur = shadow_link[slot(cur)];
        end
        return alfl_pkg::NIL;
    endfunction

    function automatic ptr_t take_free(logic [alfl_pkg::DATA_W-1:0] v);
        ptr_t n;
        n = shadow_free;
        shadow_free = shadow_link[slot(n)];
        shadow_data[slot(n)] = v;
        shadow_link[slot(n)] = alfl_pkg::NIL;
        return n;
    endfunction

    function automatic void return_free(ptr_t n);
        shadow_link[slot(n)] = shadow_free;
        shadow_free = n;
    endfunction

    // Applies one request to the shadow list and returns the reply it should produce.
    function automatic list_reply_t apply_to_shadow_list(list_req_t r);
        list_reply_t rep;
        ptr_t        n;
        ptr_t        kn;
        ptr_t        prev;
        int          s;
        rep.status = alfl_pkg::ST_OK;
        rep.removed = '0;
        if (r.kind == alfl_pkg::KIND_ADD_FRONT || r.kind == alfl_pkg::KIND_ADD_BACK ||
            r.kind == alfl_pkg::KIND_INSERT)
        begin
            if (!is_node(shadow_free))
                rep.status = alfl_pkg::ST_FULL;
            else if (!is_node(shadow_head))
            begin
                n = take_free(r.value);
                shadow_head = n;
                shadow_tail = n;
            end
            else if (r.kind == alfl_pkg::KIND_ADD_FRONT)
            begin
                n = take_free(r.value);
                shadow_link[slot(n)] = shadow_head;
                shadow_head = n;
            end
            else if (r.kind == alfl_pkg::KIND_ADD_BACK)
            begin
                n = take_free(r.value);
                if (is_node(shadow_tail))
                    shadow_link[slot(shadow_tail)] = n;
                shadow_tail = n;
            end
            else
            begin
                kn = find_first(r.key);
                if (!is_node(kn))
                    rep.status = alfl_pkg::ST_NOT_FOUND;
                else
                begin
                    n = take_free(r.value);
                    shadow_link[slot(n)] = shadow_link[slot(kn)];
                    shadow_link[slot(kn)] = n;
                    if (kn == shadow_tail)
                        shadow_tail = n;
                end
            end
        end
        else if (r.kind == alfl_pkg::KIND_REM_FRONT || r.kind == alfl_pkg::KIND_REM_BACK ||
                 r.kind == alfl_pkg::KIND_REM_AFTER)
        begin
            if (!is_node(shadow_head))
                rep.status = alfl_pkg::ST_EMPTY;
            else if (r.kind == alfl_pkg::KIND_REM_FRONT)
            begin
                n = shadow_head;
                rep.removed = shadow_data[slot(n)];
                shadow_head = shadow_link[slot(n)];
                return_free(n);
                if (!is_node(shadow_head))
                    shadow_tail = alfl_pkg::NIL;
            end
            else if (r.kind == alfl_pkg::KIND_REM_BACK)
            begin
                n = shadow_tail;
                if (!is_node(n))
                    n = shadow_head;
                rep.removed = shadow_data[slot(n)];
                if (n == shadow_head)
                begin
                    shadow_head = alfl_pkg::NIL;
                    shadow_tail = alfl_pkg::NIL;
                end
                else
                begin
                    // Walk from the front to the node just ahead of the tail.
                    prev = shadow_head;
                    for (s = 0; s < NODES; s++)
                    begin
                        if (!is_node(prev) || shadow_link[slot(prev)] == n)
                            break;
                        prev = shadow_link[slot(prev)];
                    end
                    if (is_node(prev))
                    begin
                        shadow_link[slot(prev)] = alfl_pkg::NIL;
                        shadow_tail = prev;
                    end
                end
                return_free(n);
            end
            else
            begin
                kn = find_first(r.key);
                if (!is_node(kn))
                    rep.status = alfl_pkg::ST_NOT_FOUND;
                else if (!is_node(shadow_link[slot(kn)]))
                    rep.status = alfl_pkg::ST_NOT_FOUND;
                else
                begin
                    n = shadow_link[slot(kn)];
                    rep.removed = shadow_data[slot(n)];
                    shadow_link[slot(kn)] = shadow_link[slot(n)];
                    if (n == shadow_tail)
                        shadow_tail = kn;
                    return_free(n);
                end
            end
        end
        return rep;
    endfunction

    // Data values lean on a small set so that key searches hit often.
    function automatic logic [alfl_pkg::DATA_W-1:0] pick_data();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3:       return DATA_MIN;
            4:       return DATA_MAX;
            default: return $urandom_range(0, 11) - 2;
        endcase
    endfunction

    task automatic queue_request(logic [alfl_pkg::KIND_W-1:0] k,
                                 logic [alfl_pkg::DATA_W-1:0] v,
                                 logic [alfl_pkg::DATA_W-1:0] kv);
        list_req_t r;
        r.kind = k;
        r.value = v;
        r.key = kv;
        req_backlog.push_back(r);
        requests_queued++;
    endtask

    // Queues count real requests; grow_pct sets the share of adds among them.
    task automatic queue_random(int count, int grow_pct);
        int                          done;
        logic [alfl_pkg::KIND_W-1:0] k;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 99) < 2)
                k = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
            else
            begin
                if ($urandom_range(0, 99) < grow_pct)
                    k = alfl_pkg::KIND_W'($urandom_range(0, 2));
                else
                    k = alfl_pkg::KIND_W'(3 + $urandom_range(0, 2));
                done++;
            end
            queue_request(k, pick_data(), pick_data());
        end
    endtask

    // Inputs change on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req = req_backlog.pop_front();
                    req_kind <= next_req.kind;
                    req_value <= next_req.value;
                    req_key <= next_req.key;
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Both handshakes are sampled on the rising edge.
    always @(posedge clk)
    begin
        list_reply_t exp_rep;
        list_req_t   got_req;
        if (!rst_n)
            req_taken = 1'b0;
        else
        begin
            // Replies are checked before this edge's request is predicted,
            // since a reply can never belong to a request taken on the same edge.
            if (rsp_valid && !rsp_stall)
            begin
                replies_checked++;
                status_seen[status]++;
                if (awaited_replies.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: reply with nothing outstanding: status %0d removed %0d",
                                 $realtime, status, removed_value);
                end
                else
                begin
                    exp_rep = awaited_replies.pop_front();
                    if (status !== exp_rep.status || removed_value !== exp_rep.removed)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("%0t: reply %0d expected status %0d removed %0d, got %0d %0d",
                                     $realtime, replies_checked, exp_rep.status,
                                     $signed(exp_rep.removed), status, removed_value);
                    end
                end
            end
            req_taken = req_valid && !req_stall;
            if (req_taken)
            begin
                got_req.kind = req_kind;
                got_req.value = req_value;
                got_req.key = req_key;
                awaited_replies.push_back(apply_to_shadow_list(got_req));
                requests_accepted++;
            end
        end
    end

    initial
    begin
        int phase;
        for (int i = 0; i < NODES; i++)
        begin
            shadow_data[alfl_pkg::IDX_W'(i)] = '0;
            shadow_link[alfl_pkg::IDX_W'(i)] = (i + 1 < NODES) ? ptr_t'(i + 1) : alfl_pkg::NIL;
        end
        shadow_free = '0;
        shadow_head = alfl_pkg::NIL;
        shadow_tail = alfl_pkg::NIL;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 7 : 0;
            if (phase == 0)
            begin
                // Empty list, unused kinds, insert into empty, single-node back removal.
                queue_request(alfl_pkg::KIND_REM_FRONT, '0, '0);
                queue_request(alfl_pkg::KIND_REM_BACK, '0, '0);
                queue_request(alfl_pkg::KIND_REM_AFTER, '0, '0);
                queue_request(KIND_SPARE_LO, DATA_NEG1, DATA_NEG1);
                queue_request(KIND_SPARE_HI, DATA_MAX, DATA_MIN);
                queue_request(alfl_pkg::KIND_INSERT, DATA_MIN, DATA_MAX);
                queue_request(alfl_pkg::KIND_REM_BACK, '0, '0);
                // Tail upkeep after inserts and removals at the end.
                queue_request(alfl_pkg::KIND_ADD_BACK, DATA_MAX, '0);
                queue_request(alfl_pkg::KIND_ADD_FRONT, '0, '0);
                queue_request(alfl_pkg::KIND_ADD_BACK, DATA_NEG1, '0);
                queue_request(alfl_pkg::KIND_INSERT, 32'd5, DATA_NEG1);
                queue_request(alfl_pkg::KIND_ADD_BACK, 32'd7, '0);
                queue_request(alfl_pkg::KIND_REM_AFTER, '0, 32'd5);
                queue_request(alfl_pkg::KIND_REM_AFTER, '0, 32'd5);
                queue_request(alfl_pkg::KIND_INSERT, 32'd1, 32'd12345);
                queue_request(alfl_pkg::KIND_REM_AFTER, '0, 32'd12345);
                queue_request(alfl_pkg::KIND_INSERT, 32'd2, '0);
                queue_request(alfl_pkg::KIND_REM_BACK, '0, '0);
                queue_request(alfl_pkg::KIND_ADD_BACK, 32'd9, '0);
                queue_request(alfl_pkg::KIND_REM_FRONT, '0, '0);
                queue_request(alfl_pkg::KIND_REM_AFTER, '0, 32'd2);
                queue_request(alfl_pkg::KIND_ADD_FRONT, 32'h5555_5555, '0);
                queue_request(alfl_pkg::KIND_INSERT, 32'haaaa_aaaa, 32'h5555_5555);
                queue_request(alfl_pkg::KIND_REM_FRONT, '0, '0);
            end
            // Fill until full, drain until empty, then a mixed stretch.
            queue_random(80, 95);
            queue_random(80, 8);
            queue_random(15, 50);
            // The sender holds off here until every reply has come back.
            while (requests_accepted != requests_queued || awaited_replies.size() != 0)
                @(negedge clk);
        end

        repeat (NODES + 10) @(posedge clk);
        $display("Ran %0d requests over three stall patterns, from empty to full and back.",
                 requests_accepted);
        $display("Replies: %0d ok, %0d full, %0d empty, %0d key missing; %0d mismatches.",
                 status_seen[alfl_pkg::ST_OK], status_seen[alfl_pkg::ST_FULL],
                 status_seen[alfl_pkg::ST_EMPTY], status_seen[alfl_pkg::ST_NOT_FOUND],
                 failures);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout with %0d replies still outstanding.", awaited_replies.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
